@@ hdl/mfd_pkg.sv @@
// mfd_pkg: widths, constants, register indexes and shared types of the
// modulated fractional delay line. No dependencies.
`default_nettype none

package mfd_pkg;

	localparam int DEPTH      = 4096;
	localparam int CHANNELS   = 2;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ADDR_W     = CH_W + PTR_W;
	localparam int RAM_DEPTH  = 2 ** ADDR_W;

	localparam int SAMPLE_W   = 24;
	localparam int MOD_W      = 24;
	localparam int BASE_W     = 28;
	localparam int RATE_W     = 18;
	localparam int FRAC_W     = 16;
	localparam int TOT_W      = PTR_W + FRAC_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 28;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = CFG_IDX_W'(1);
	localparam logic [BASE_W-1:0]    BASE_RESET      = BASE_W'(62914560);
	localparam logic [RATE_W-1:0]    RATE_RESET      = RATE_W'(48000);

	// mod_ms * sample_rate, then floor division by 1000 = 8 * 125
	localparam int PROD_W      = MOD_W + RATE_W + 1;
	localparam int DIV_SH      = 3;
	localparam int DIV_SUB     = 125;
	localparam int DIV_BIAS_SH = 32;
	localparam int DIV_W       = 40;
	localparam int REM_W       = $clog2(DIV_SUB);
	localparam int Q_W         = DIV_BIAS_SH + 1;
	localparam int OFF_W       = Q_W + 1;
	localparam logic [PROD_W-1:0] DIV_BIAS = PROD_W'(DIV_SUB) << DIV_BIAS_SH;

	// division by 125 on two halves, reciprocal exact for operands below 2 ** RED_W
	localparam int DIV_SPLIT = DIV_W / 2;
	localparam int RED_W     = REM_W + DIV_SPLIT;
	localparam int RCP_W     = 28;
	localparam int RCP_SH    = RED_W + REM_W;
	localparam int RP_W      = RED_W + RCP_W;
	localparam int QH_W      = Q_W - DIV_SPLIT;
	localparam logic [RCP_W-1:0] DIV_RCP = RCP_W'(137438954);

	localparam int TSUM_W = OFF_W + 1;
	localparam logic signed [TSUM_W-1:0] TOP_DELAY = TSUM_W'(DEPTH - 1) << FRAC_W;

	localparam int MAC_W = SAMPLE_W + FRAC_W + 2;
	localparam int SUM_W = MAC_W + 1;

	typedef struct packed {
		logic                    done;
		logic signed [OFF_W-1:0] off;
	} div_res_t;

endpackage

`default_nettype wire

@@ hdl/mfd_in_if.sv @@
// mfd_in_if: input sample channel, valid/ready with sample, channel, modulation.
// Depends on mfd_pkg.
`default_nettype none

interface mfd_in_if import mfd_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       chan;
	logic signed [MOD_W-1:0]    mod_ms;

	modport source (output valid, sample_in, chan, mod_ms, input ready);
	modport sink   (input valid, sample_in, chan, mod_ms, output ready);
endinterface

`default_nettype wire

@@ hdl/mfd_out_if.sv @@
// mfd_out_if: result channel, valid/ready with the interpolated sample.
// Depends on mfd_pkg.
`default_nettype none

interface mfd_out_if import mfd_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;

	modport source (output valid, sample_out, input ready);
	modport sink   (input valid, sample_out, output ready);
endinterface

`default_nettype wire

@@ hdl/mfd_cfg_if.sv @@
// mfd_cfg_if: register write channel, valid/ready with index and data.
// Depends on mfd_pkg.
`default_nettype none

interface mfd_cfg_if import mfd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/mfd_ram.sv @@
// mfd_ram: generic simple dual-port ram, one write port, one registered read port.
// No dependencies.
`default_nettype none

module mfd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ hdl/mfd_div.sv @@
// mfd_div: floor division of the signed product by 1000, by reciprocal
// multiplication on the two halves of the biased value. Depends on mfd_pkg.
`default_nettype none

module mfd_div import mfd_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [PROD_W-1:0] dividend,
	output      div_res_t                 res
);

	logic                 busy_q;
	logic                 step_q;
	logic                 half_q;
	logic                 done_q;
	logic [DIV_SPLIT-1:0] lo_q;
	logic [RED_W-1:0]     x_q;
	logic [RP_W-1:0]      p_q;
	logic [QH_W-1:0]      qh_q;
	logic [DIV_SPLIT-1:0] ql_q;
	logic [PROD_W-1:0]    v_load;
	logic [DIV_SPLIT-1:0] qpart;
	logic [RED_W-1:0]     qmul;
	logic [RED_W-1:0]     rdiff;
	logic [Q_W-1:0]       q_all;

	// biased so the value is never negative, divided by 8 exactly by the shift
	assign v_load = PROD_W'(dividend >>> DIV_SH) + DIV_BIAS;

	// quotient and remainder by 125 of x_q, from the product of the cycle before
	assign qpart = p_q[RCP_SH +: DIV_SPLIT];
	assign qmul  = RED_W'(qpart) * RED_W'(DIV_SUB);
	assign rdiff = x_q - qmul;
	assign q_all = {qh_q, ql_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 1'b0;
			half_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && step_q && half_q;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 1'b0;
				half_q <= 1'b0;
			end else if (busy_q) begin
				step_q <= !step_q;
				if (step_q) begin
					half_q <= 1'b1;
					if (half_q) begin
						busy_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q  <= RED_W'(v_load[DIV_W-1:DIV_SPLIT]);
			lo_q <= v_load[DIV_SPLIT-1:0];
		end else if (busy_q && !step_q) begin
			p_q <= RP_W'(x_q) * RP_W'(DIV_RCP);
		end else if (busy_q && !half_q) begin
			qh_q <= qpart[QH_W-1:0];
			x_q  <= {rdiff[REM_W-1:0], lo_q};
		end else if (busy_q) begin
			ql_q <= qpart;
		end
	end

	assign res.done = done_q;
	assign res.off  = $signed(OFF_W'({1'b0, q_all}) - (OFF_W'(1) << DIV_BIAS_SH));

endmodule

`default_nettype wire

@@ hdl/modulated_fractional_delay.sv @@
// modulated_fractional_delay: per-channel circular delay line with linear
// interpolation. Depends on mfd_pkg, the channel interfaces, mfd_div and mfd_ram.
//
// Each input beat carries a sample, its channel and a modulation offset in
// milliseconds (Q.16). The delay is base_delay + floor(mod_ms * sample_rate /
// 1000), clamped to [0, DEPTH-1] samples; the two neighboring stored samples are
// blended by its 16-bit fraction and rounded. From acceptance to its result at the
// output, an item passes through a multiply, the load of the divide-by-1000 unit,
// reciprocal multiplication on the two halves of the product, the add and clamp
// of the delay, address generation, two reads of the single-read-port sample
// memory, a multiply and the write-back. The input is ready again right after
// the write-back. A new beat is taken while a result still waits at the output;
// only its write-back waits for the output to free. Both channels share one
// memory; slots not yet written since reset read as zero through a per-channel
// wrap flag, so no clearing pass is needed.
`default_nettype none

module modulated_fractional_delay import mfd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	mfd_cfg_if.sink   cfg,
	mfd_in_if.sink    samples,
	mfd_out_if.source results
);

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] S_IDLE   = ST_W'(0);
	localparam logic [ST_W-1:0] S_MUL    = ST_W'(1);
	localparam logic [ST_W-1:0] S_DSTART = ST_W'(2);
	localparam logic [ST_W-1:0] S_DIV    = ST_W'(3);
	localparam logic [ST_W-1:0] S_ADR    = ST_W'(4);
	localparam logic [ST_W-1:0] S_RD1    = ST_W'(5);
	localparam logic [ST_W-1:0] S_RD2    = ST_W'(6);
	localparam logic [ST_W-1:0] S_MAC    = ST_W'(7);
	localparam logic [ST_W-1:0] S_OUT    = ST_W'(8);

	logic [ST_W-1:0]            state_q;
	logic [BASE_W-1:0]          base_q;
	logic [RATE_W-1:0]          rate_q;
	logic [PTR_W-1:0]           wp_q [CHANNELS];
	logic [CHANNELS-1:0]        wrap_q;

	logic signed [SAMPLE_W-1:0] x_q;
	logic [CH_W-1:0]            ch_q;
	logic signed [MOD_W-1:0]    mod_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic [TOT_W-1:0]           tot_q;
	logic [PTR_W-1:0]           a1_q;
	logic [PTR_W-1:0]           a2_q;
	logic                       v1_q;
	logic                       v2_q;
	logic signed [SAMPLE_W-1:0] s1_q;
	logic signed [MAC_W-1:0]    m1_q;
	logic signed [MAC_W-1:0]    m2_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_q;

	div_res_t                   div_res;
	logic                       div_start;
	logic signed [TSUM_W-1:0]   tsum;
	logic [TOT_W-1:0]           tot_clamp;
	logic [PTR_W-1:0]           d;
	logic [FRAC_W-1:0]          f;
	logic [PTR_W-1:0]           wp;
	logic [PTR_W:0]             dp1;
	logic [PTR_W-1:0]           a1;
	logic [PTR_W-1:0]           a2;
	logic [FRAC_W:0]            w1;
	logic signed [SUM_W-1:0]    sum;
	logic                       accept;
	logic                       out_free;
	logic                       fire;
	logic                       ram_we;
	logic                       ram_re;
	logic [ADDR_W-1:0]          ram_raddr;
	logic [SAMPLE_W-1:0]        ram_rdata;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			rate_q <= RATE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BASE_DELAY:  base_q <= cfg.data[BASE_W-1:0];
				REG_SAMPLE_RATE: rate_q <= cfg.data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// handshakes
	assign samples.ready = (state_q == S_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign out_free      = !out_valid_q || results.ready;
	assign fire          = (state_q == S_OUT) && out_free;
	assign div_start     = (state_q == S_DSTART);

	mfd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.res      (div_res)
	);

	// total delay and clamp
	assign tsum = $signed({{(TSUM_W-BASE_W){1'b0}}, base_q}) +
		$signed({div_res.off[OFF_W-1], div_res.off});

	always_comb begin
		if (tsum < $signed(TSUM_W'(0))) begin
			tot_clamp = '0;
		end else if (tsum > TOP_DELAY) begin
			tot_clamp = TOP_DELAY[TOT_W-1:0];
		end else begin
			tot_clamp = tsum[TOT_W-1:0];
		end
	end

	// read addresses behind the write pointer
	assign d   = tot_q[TOT_W-1:FRAC_W];
	assign f   = tot_q[FRAC_W-1:0];
	assign wp  = wp_q[ch_q];
	assign dp1 = {1'b0, d} + (PTR_W+1)'(1);
	assign a1  = (wp >= d) ? (wp - d) :
		PTR_W'({1'b0, wp} + (PTR_W+1)'(DEPTH) - {1'b0, d});
	assign a2  = ({1'b0, wp} >= dp1) ? PTR_W'({1'b0, wp} - dp1) :
		PTR_W'({1'b0, wp} + (PTR_W+1)'(DEPTH) - dp1);

	assign w1  = (FRAC_W+1)'(1) << FRAC_W;
	assign sum = SUM_W'(m1_q) + SUM_W'(m2_q) + (SUM_W'(1) << (FRAC_W - 1));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:   if (accept) state_q <= S_MUL;
				S_MUL:    state_q <= S_DSTART;
				S_DSTART: state_q <= S_DIV;
				S_DIV:    if (div_res.done) state_q <= S_ADR;
				S_ADR:    state_q <= S_RD1;
				S_RD1:    state_q <= S_RD2;
				S_RD2:    state_q <= S_MAC;
				S_MAC:    state_q <= S_OUT;
				S_OUT:    if (out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= samples.sample_in;
			ch_q  <= (CHANNELS == 1) ? '0 : CH_W'(samples.chan);
			mod_q <= samples.mod_ms;
		end
		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(mod_q) * $signed({1'b0, rate_q});
		end
		if (state_q == S_DIV && div_res.done) begin
			tot_q <= tot_clamp;
		end
		if (state_q == S_ADR) begin
			a1_q <= a1;
			a2_q <= a2;
			v1_q <= wrap_q[ch_q] || (a1 < wp);
			v2_q <= wrap_q[ch_q] || (a2 < wp);
		end
		if (state_q == S_RD2) begin
			s1_q <= v1_q ? $signed(ram_rdata) : '0;
		end
		if (state_q == S_MAC) begin
			m1_q <= MAC_W'(s1_q) * $signed({1'b0, w1 - {1'b0, f}});
			m2_q <= MAC_W'(v2_q ? $signed(ram_rdata) : SAMPLE_W'(0)) *
				$signed({2'b0, f});
		end
		if (fire) begin
			out_q <= sum[FRAC_W +: SAMPLE_W];
		end
	end

	// write pointers and wrap flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				wp_q[c] <= '0;
			end
			wrap_q <= '0;
		end else if (fire) begin
			if (wp == PTR_W'(DEPTH - 1)) begin
				wp_q[ch_q]   <= '0;
				wrap_q[ch_q] <= 1'b1;
			end else begin
				wp_q[ch_q] <= wp + PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.sample_out = out_q;

	// sample memory, both channels
	assign ram_we    = fire;
	assign ram_re    = (state_q == S_RD1) || (state_q == S_RD2);
	assign ram_raddr = (state_q == S_RD1) ? {ch_q, a1_q} : {ch_q, a2_q};

	mfd_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr ({ch_q, wp}),
		.wdata (x_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// checks
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_MUL)
		else $error("accepted beat did not start the multiply");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == S_DIV)
		else $error("divider finished outside its wait state");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !ram_re)
		else $error("memory read and write in the same cycle");

	a_wp_moves_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(wp_q[0]) |-> $past(ram_we))
		else $error("write pointer moved without a write");

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> results.valid)
		else $error("finished result not presented");

endmodule

`default_nettype wire
